[design/assert_macros.svh]
// Assertion macros used by the checker module.
// Depends on nothing; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// implication shorthand on the same clock and reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	`ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons))

`endif

[design/mrs_pkg.sv]
// Types and constants for the matrix repeated squaring block.
// No dependencies; used by every design file but mrs_ram.
package mrs_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 3;
	localparam int SIZE_W = 4;
	localparam int CNT8_W = 8;

	localparam logic REG_DIM          = 1'b0;
	localparam logic REG_SQUARE_COUNT = 1'b1;

	localparam logic [SIZE_W-1:0] SIZE_RESET  = 4'd8;
	localparam logic [CNT8_W-1:0] COUNT_RESET = 8'd1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_XFER,
		ST_XWAIT,
		ST_SQUARE,
		ST_DRAIN,
		ST_COPY,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [IDX_W-1:0]  i;
		logic [IDX_W-1:0]  j;
		logic [DATA_W-1:0] acc;
	} chain_t;

	typedef struct packed {
		logic              valid;
		logic [IDX_W-1:0]  r;
		logic [IDX_W-1:0]  c;
		logic [DATA_W-1:0] data;
	} wr_t;

endpackage

[design/mrs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/mrs_cell.sv]
// One cell of the multiply-accumulate chain: holds row K and column K of the
// working and product matrices. Depends on mrs_pkg.
module mrs_cell #(
	parameter int MAX_DIM = 8,
	parameter int K       = 0
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  active,
	input  mrs_pkg::wr_t                          work_wr,
	input  mrs_pkg::wr_t                          prod_wr,
	input  logic                                  copy_en,
	input  mrs_pkg::chain_t                       chain_in,
	output mrs_pkg::chain_t                       chain_out,
	input  logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0] rd_idx,
	output logic [mrs_pkg::DATA_W-1:0]            rd_data
);

	localparam int IW = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;
	localparam logic [mrs_pkg::IDX_W-1:0] KI = mrs_pkg::IDX_W'(K);

	logic [mrs_pkg::DATA_W-1:0] wrow_q [MAX_DIM];
	logic [mrs_pkg::DATA_W-1:0] wcol_q [MAX_DIM];
	logic [mrs_pkg::DATA_W-1:0] prow_q [MAX_DIM];
	logic [mrs_pkg::DATA_W-1:0] pcol_q [MAX_DIM];

	logic                       v_s1, v_s2;
	logic [mrs_pkg::IDX_W-1:0]  i_s1, j_s1, i_s2, j_s2;
	logic [mrs_pkg::DATA_W-1:0] acc_s1, mul_s1, acc_s2;
	logic [2*mrs_pkg::DATA_W-1:0] mul_full;

	assign mul_full = wrow_q[chain_in.j[IW-1:0]] * wcol_q[chain_in.i[IW-1:0]];

	always_ff @(posedge clk) begin
		if (copy_en) begin
			wrow_q <= prow_q;
			wcol_q <= pcol_q;
		end else if (work_wr.valid) begin
			if (work_wr.r == KI) begin
				wrow_q[work_wr.c[IW-1:0]] <= work_wr.data;
			end
			if (work_wr.c == KI) begin
				wcol_q[work_wr.r[IW-1:0]] <= work_wr.data;
			end
		end
		if (prod_wr.valid) begin
			if (prod_wr.r == KI) begin
				prow_q[prod_wr.c[IW-1:0]] <= prod_wr.data;
			end
			if (prod_wr.c == KI) begin
				pcol_q[prod_wr.r[IW-1:0]] <= prod_wr.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= chain_in.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		i_s1   <= chain_in.i;
		j_s1   <= chain_in.j;
		acc_s1 <= chain_in.acc;
		mul_s1 <= active ? mul_full[mrs_pkg::DATA_W-1:0] : '0;
		i_s2   <= i_s1;
		j_s2   <= j_s1;
		acc_s2 <= acc_s1 + mul_s1;
	end

	assign chain_out.valid = v_s2;
	assign chain_out.i     = i_s2;
	assign chain_out.j     = j_s2;
	assign chain_out.acc   = acc_s2;

	assign rd_data = wrow_q[rd_idx];

endmodule

[design/matrix_repeated_squaring.sv]
// Matrix repeated squaring: loads an n x n integer matrix, squares it a set
// number of times in a chain of MAC cells, and returns the result row-major.
// Depends on mrs_pkg, mrs_ram, mrs_cell.
//
// Use: write the size register (index 0) and square_count (index 1) while idle.
// Elements come in row-major on the input channel, one per transfer. After
// the n*n-th element the input stalls; the matrix is moved from the load RAM
// into the cells, then each squaring injects one product element per cycle
// into the chain of MAX_DIM cells and waits for it to drain, for a time set
// by the chain length. The final matrix leaves one element per cycle,
// last_of_run on the last one; a stall on the output holds the current
// result and pauses the emission. Input is taken again once the last
// result sits in the output register. Reset empties the load count, drops
// any output and restores the registers to size 8 and one squaring.
module matrix_repeated_squaring #(
	parameter int MAX_DIM = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [mrs_pkg::DATA_W-1:0]  element,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [mrs_pkg::DATA_W-1:0]  value,
	output logic                               last_of_run,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [mrs_pkg::CNT8_W-1:0]         cfg_data
);

	localparam int IW      = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;
	localparam int DEPTH   = MAX_DIM * MAX_DIM;
	localparam int AW      = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int CW      = $clog2(DEPTH + 1);
	localparam int DW      = $clog2(2 * MAX_DIM + 1);
	localparam logic [DW-1:0] DRAIN_LEN = DW'(2 * MAX_DIM);
	localparam logic [mrs_pkg::SIZE_W-1:0] MAX_N = mrs_pkg::SIZE_W'(MAX_DIM);

	mrs_pkg::state_t state_q, state_d;

	logic [mrs_pkg::SIZE_W-1:0] size_q, n_eff;
	logic [mrs_pkg::CNT8_W-1:0] count_q, pass_q;
	logic [CW-1:0]              load_cnt_q, cells;
	logic [AW-1:0]              addr_q;
	logic [mrs_pkg::IDX_W-1:0]  r_q, c_q, nm1;
	logic [DW-1:0]              drain_q;
	logic                       rc_last, in_xfer, load_done, emit_go;
	logic                       xv_s1;
	logic [mrs_pkg::IDX_W-1:0]  xr_s1, xc_s1;
	logic [mrs_pkg::DATA_W-1:0] ram_rdata;
	logic                       out_valid_q, last_q;
	logic [mrs_pkg::DATA_W-1:0] value_q;

	mrs_pkg::wr_t    work_wr, prod_wr;
	mrs_pkg::chain_t chain [MAX_DIM + 1];
	logic [mrs_pkg::DATA_W-1:0] rd_data [MAX_DIM];

	assign n_eff = (size_q == '0) ? mrs_pkg::SIZE_W'(1) :
		(size_q > MAX_N) ? MAX_N : size_q;
	assign nm1     = mrs_pkg::IDX_W'(n_eff - mrs_pkg::SIZE_W'(1));
	assign cells   = CW'(n_eff) * CW'(n_eff);
	assign rc_last = (r_q == nm1) && (c_q == nm1);
	assign in_xfer = in_valid && !in_stall;
	assign load_done = (load_cnt_q + CW'(1)) >= cells;
	assign emit_go = (state_q == mrs_pkg::ST_EMIT) && (!out_valid_q || !out_stall);

	assign in_stall = (state_q != mrs_pkg::ST_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= mrs_pkg::SIZE_RESET;
			count_q <= mrs_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mrs_pkg::REG_DIM:          size_q  <= cfg_data[mrs_pkg::SIZE_W-1:0];
				mrs_pkg::REG_SQUARE_COUNT: count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mrs_ram #(
		.WIDTH(mrs_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_load_ram (
		.clk  (clk),
		.we   (in_xfer),
		.waddr(load_cnt_q[AW-1:0]),
		.wdata(element),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrs_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mrs_pkg::ST_LOAD: begin
				if (in_xfer && load_done) state_d = mrs_pkg::ST_XFER;
			end
			mrs_pkg::ST_XFER: begin
				if (rc_last) state_d = mrs_pkg::ST_XWAIT;
			end
			mrs_pkg::ST_XWAIT: begin
				state_d = (count_q == '0) ? mrs_pkg::ST_EMIT : mrs_pkg::ST_SQUARE;
			end
			mrs_pkg::ST_SQUARE: begin
				if (rc_last) state_d = mrs_pkg::ST_DRAIN;
			end
			mrs_pkg::ST_DRAIN: begin
				if (drain_q == DRAIN_LEN) state_d = mrs_pkg::ST_COPY;
			end
			mrs_pkg::ST_COPY: begin
				state_d = (pass_q == mrs_pkg::CNT8_W'(1)) ? mrs_pkg::ST_EMIT :
					mrs_pkg::ST_SQUARE;
			end
			mrs_pkg::ST_EMIT: begin
				if (emit_go && rc_last) state_d = mrs_pkg::ST_LOAD;
			end
			default: state_d = mrs_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q  <= '0;
			addr_q      <= '0;
			r_q         <= '0;
			c_q         <= '0;
			pass_q      <= '0;
			drain_q     <= '0;
			xv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			xv_s1 <= (state_q == mrs_pkg::ST_XFER);
			if (in_xfer) begin
				load_cnt_q <= load_done ? '0 : load_cnt_q + CW'(1);
				if (load_done) begin
					addr_q <= '0;
					r_q    <= '0;
					c_q    <= '0;
				end
			end
			if (state_q == mrs_pkg::ST_XFER) begin
				addr_q <= addr_q + AW'(1);
			end
			if (state_q == mrs_pkg::ST_XFER || state_q == mrs_pkg::ST_SQUARE ||
				emit_go) begin
				if (c_q == nm1) begin
					c_q <= '0;
					r_q <= (r_q == nm1) ? '0 : r_q + mrs_pkg::IDX_W'(1);
				end else begin
					c_q <= c_q + mrs_pkg::IDX_W'(1);
				end
			end
			if (state_q == mrs_pkg::ST_XWAIT) begin
				pass_q <= count_q;
			end
			if (state_q == mrs_pkg::ST_COPY) begin
				pass_q <= pass_q - mrs_pkg::CNT8_W'(1);
			end
			drain_q <= (state_q == mrs_pkg::ST_DRAIN) ? drain_q + DW'(1) : '0;
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		xr_s1 <= r_q;
		xc_s1 <= c_q;
		if (emit_go) begin
			value_q <= rd_data[r_q[IW-1:0]];
			last_q  <= rc_last;
		end
	end

	assign work_wr.valid = xv_s1;
	assign work_wr.r     = xr_s1;
	assign work_wr.c     = xc_s1;
	assign work_wr.data  = ram_rdata;

	assign chain[0].valid = (state_q == mrs_pkg::ST_SQUARE);
	assign chain[0].i     = r_q;
	assign chain[0].j     = c_q;
	assign chain[0].acc   = '0;

	assign prod_wr.valid = chain[MAX_DIM].valid;
	assign prod_wr.r     = chain[MAX_DIM].i;
	assign prod_wr.c     = chain[MAX_DIM].j;
	assign prod_wr.data  = chain[MAX_DIM].acc;

	for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
		mrs_cell #(
			.MAX_DIM(MAX_DIM),
			.K      (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.active   (mrs_pkg::SIZE_W'(k) < n_eff),
			.work_wr  (work_wr),
			.prod_wr  (prod_wr),
			.copy_en  (state_q == mrs_pkg::ST_COPY),
			.chain_in (chain[k]),
			.chain_out(chain[k+1]),
			.rd_idx   (c_q[IW-1:0]),
			.rd_data  (rd_data[k])
		);
	end

	assign out_valid   = out_valid_q;
	assign value       = value_q;
	assign last_of_run = last_q;

endmodule

[design/mrs_checker.sv]
// Port-level checks for matrix_repeated_squaring, bound to the top level.
// Depends on assert_macros.svh and mrs_pkg.
`include "assert_macros.svh"

module mrs_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [mrs_pkg::DATA_W-1:0] value,
	input logic                       last_of_run
);

	logic out_hold, out_xfer;

	assign out_hold = out_valid && out_stall;
	assign out_xfer = out_valid && !out_stall;

	// a held result does not change
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_hold |=> out_valid && $stable(value) && $stable(last_of_run))

	// no new matrix is taken in the middle of an emission
	`ASSERT_IMPL(a_no_load_mid_run, clk, arst_n, out_valid && !last_of_run, in_stall)

	// results of one run follow without a gap while they are taken
	`ASSERT_CLK(a_run_no_gap, clk, arst_n, out_xfer && !last_of_run |=> out_valid)

	// nothing is taken on input while a run is emitted and stalled
	`ASSERT_CLK(a_stall_no_take, clk, arst_n, out_hold && !last_of_run |=> in_stall)

endmodule

bind matrix_repeated_squaring mrs_checker u_mrs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.value      (value),
	.last_of_run(last_of_run)
);

[bench/tb_matrix_repeated_squaring.sv]
// Self-checking bench for matrix_repeated_squaring: drives matrices through the
// valid/stall channels and checks each emitted element against a local predictor.
// Depends on mrs_pkg and the matrix_repeated_squaring RTL.
module tb_matrix_repeated_squaring;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIM_MAX = 8;
	localparam int CYCLE_LIMIT = 10000000;

	typedef struct {
		logic [mrs_pkg::DATA_W-1:0] value;
		logic                       last;
	} elem_exp_t;

	class squaring_scoreboard;
		logic [mrs_pkg::DATA_W-1:0] work[DIM_MAX*DIM_MAX];
		logic [mrs_pkg::DATA_W-1:0] prod[DIM_MAX*DIM_MAX];
		int unsigned                loaded;
		logic [mrs_pkg::SIZE_W-1:0] size_reg;
		logic [mrs_pkg::CNT8_W-1:0] squares_reg;
		elem_exp_t                  pending_elems[$];
		int                         errors;

		function new();
			loaded = 0;
			size_reg = mrs_pkg::SIZE_RESET;
			squares_reg = mrs_pkg::COUNT_RESET;
			errors = 0;
		endfunction

		function void set_reg(logic idx, logic [mrs_pkg::CNT8_W-1:0] data);
			if (idx == mrs_pkg::REG_DIM)
				size_reg = data[mrs_pkg::SIZE_W-1:0];
			else
				squares_reg = data;
		endfunction

		function int dim();
			int n;
			n = int'(size_reg);
			if (n < 1) n = 1;
			if (n > DIM_MAX) n = DIM_MAX;
			return n;
		endfunction

		function void note_element(logic [mrs_pkg::DATA_W-1:0] e);
			int n;
			int cells;
			logic [mrs_pkg::DATA_W-1:0] acc;
			elem_exp_t x;
			n = dim();
			cells = n * n;
			if (loaded < DIM_MAX*DIM_MAX)
				work[loaded] = e;
			loaded = (loaded + 1) & 7'h7f;
			if (loaded < cells)
				return;
			for (int r = 0; r < int'(squares_reg); r++) begin
				for (int i = 0; i < n; i++)
					for (int j = 0; j < n; j++) begin
						acc = '0;
						for (int k = 0; k < n; k++)
							acc += work[i*n+k] * work[k*n+j];
						prod[i*n+j] = acc;
					end
				for (int t = 0; t < cells; t++)
					work[t] = prod[t];
			end
			for (int t = 0; t < cells; t++) begin
				x.value = work[t];
				x.last = (t + 1 == cells);
				pending_elems.push_back(x);
			end
			loaded = 0;
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_result(logic [mrs_pkg::DATA_W-1:0] v, logic l);
			elem_exp_t x;
			if (pending_elems.size() == 0) begin
				report($sformatf("unexpected value %h last %b", v, l));
				return;
			end
			x = pending_elems.pop_front();
			if (v !== x.value)
				report($sformatf("value %h, want %h", v, x.value));
			if (l !== x.last)
				report($sformatf("last_of_run %b, want %b", l, x.last));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [mrs_pkg::DATA_W-1:0] element;
	logic out_valid;
	logic out_stall;
	logic signed [mrs_pkg::DATA_W-1:0] value;
	logic last_of_run;
	logic cfg_we;
	logic cfg_index;
	logic [mrs_pkg::CNT8_W-1:0] cfg_data;

	squaring_scoreboard sb;
	int cycles;
	int stall_left;
	bit no_gaps;
	int items_sent;

	matrix_repeated_squaring #(.MAX_DIM(DIM_MAX)) dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(value, last_of_run);
			stall_left = no_gaps ? 0 : $urandom_range(0, 16);
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task send_element(logic [mrs_pkg::DATA_W-1:0] e);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		element = e;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_element(e);
		items_sent++;
		@(negedge clk);
	endtask

	task settle();
		in_valid = 1'b0;
		while (sb.pending_elems.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task write_reg(logic idx, logic [mrs_pkg::CNT8_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task set_mode(logic [mrs_pkg::SIZE_W-1:0] size, logic [mrs_pkg::CNT8_W-1:0] squares);
		settle();
		write_reg(mrs_pkg::REG_DIM, {4'($urandom_range(0, 15)), size});
		write_reg(mrs_pkg::REG_SQUARE_COUNT, squares);
	endtask

	function automatic logic [mrs_pkg::DATA_W-1:0] pick_element();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2, 3: return $urandom();
			default: return $urandom_range(0, 6) - 3;
		endcase
	endfunction

	task send_matrices(int count);
		int n;
		n = sb.dim();
		for (int m = 0; m < count; m++)
			for (int t = 0; t < n*n; t++)
				send_element(pick_element());
	endtask

	initial begin
		logic [mrs_pkg::SIZE_W-1:0] size;
		logic [mrs_pkg::CNT8_W-1:0] squares;
		sb = new();
		no_gaps = 1'b0;
		items_sent = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		element = '0;
		cfg_we = 1'b0;
		cfg_index = mrs_pkg::REG_DIM;
		cfg_data = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset defaults first: size 8, one squaring
		send_matrices(1);
		set_mode(4'd1, 8'd0);
		send_element(32'h8000_0000);
		send_element(32'h7fff_ffff);
		send_element(32'hffff_ffff);
		send_element(32'h0000_0000);
		set_mode(4'd0, 8'd255);
		send_element(32'h0000_0003);
		send_element(32'hffff_ffff);
		set_mode(4'd2, 8'd1);
		send_element(32'h7fff_ffff);
		send_element(32'h8000_0000);
		send_element(32'hffff_ffff);
		send_element(32'h0000_0001);
		set_mode(4'd15, 8'd0);
		send_matrices(1);
		set_mode(4'd8, 8'd255);
		send_matrices(1);

		while (items_sent < 370) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 7) == 0)
				size = 4'($urandom_range(8, 15));
			else
				size = 4'($urandom_range(0, 4));
			if (size <= 2)
				squares = 8'($urandom_range(0, 255));
			else
				squares = 8'($urandom_range(0, 4));
			set_mode(size, squares);
			send_matrices($urandom_range(1, 3));
		end

		settle();
		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.pending_elems.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

[matrix_repeated_squaring.f]
+incdir+design
design/mrs_pkg.sv
design/mrs_ram.sv
design/mrs_cell.sv
design/matrix_repeated_squaring.sv
design/mrs_checker.sv
bench/tb_matrix_repeated_squaring.sv
